// ===== hw/rtl/dtdf_pkg.sv =====
package dtdf_pkg;

  localparam int unsigned DBL_EXP_W   = 11;
  localparam int unsigned DBL_FRAC_W  = 52;
  localparam logic [DBL_EXP_W-1:0] DBL_EXP_SPECIAL = 11'h7FF;
  localparam logic [DBL_EXP_W-1:0] DBL_EXP_DENORM  = 11'h000;
  localparam int signed   DBL_BIAS    = 1023;
  localparam int unsigned EXP_W       = 13;   // signed unbiased exponent width
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned EXP_FIELD_W = 8;

  typedef logic signed [EXP_W-1:0] exp_t;

endpackage

// ===== hw/rtl/double_to_dsp_float_core.sv =====
// Data path: an accepted input is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle; one more transaction waits in the input register
// while a result is stalled, then the input stalls.
// Reset: synchronous active-low rst_n clears both valid flags; payload registers are not reset.
// Subnormals always underflow to 0, so no normalizing shift is needed.
module double_to_dsp_float_core
  import dtdf_pkg::*;
#(
  parameter int MANT_BITS = 23,
  parameter int EXP_BIAS  = 128,
  parameter int EXP_MAX   = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          in_double_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_dsp_word
);

  localparam int RND_IDX = DBL_FRAC_W - 1 - MANT_BITS;
  localparam exp_t E_MIN = exp_t'(-(EXP_BIAS - 1));
  localparam exp_t E_TOP = exp_t'(EXP_MAX - EXP_BIAS);
  localparam logic [EXP_FIELD_W-1:0] EXP_MASK = EXP_FIELD_W'(EXP_MAX);

  logic              in_v_r;
  logic [63:0]       dbl_r;
  logic              out_v_r;
  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic              adv;

  assign adv      = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !adv;
  assign out_valid    = out_v_r;
  assign out_dsp_word = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) in_v_r <= in_valid;
      if (adv) out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) dbl_r <= in_double_bits;
    if (adv) word_r <= word_nxt;
  end

  logic                  sgn;
  logic [DBL_EXP_W-1:0]  ef;
  logic [DBL_FRAC_W-1:0] fr;
  logic [MANT_BITS+1:0]  rsum;
  logic                  carry;
  logic                  is_pow;
  logic [MANT_BITS-1:0]  mant;
  logic [MANT_BITS+1:0]  rneg;
  exp_t                  e0;
  exp_t                  e;
  logic [EXP_FIELD_W-1:0] efield;
  logic [MANT_BITS-1:0]  ovf_mant;

  always_comb begin
    sgn  = dbl_r[63];
    ef   = dbl_r[62:52];
    fr   = dbl_r[51:0];
    rsum = {1'b0, 1'b1, fr[DBL_FRAC_W-1 -: MANT_BITS]} + (MANT_BITS+2)'(fr[RND_IDX]);
    carry  = rsum[MANT_BITS+1];
    is_pow = carry || (rsum[MANT_BITS-1:0] == '0);
    rneg   = ~rsum + 1'b1;
    e0 = exp_t'({2'b00, ef}) - exp_t'(DBL_BIAS) + exp_t'(carry);
    if (sgn) begin
      mant = is_pow ? '0 : rneg[MANT_BITS-1:0];
      e    = is_pow ? e0 - exp_t'(1) : e0;
    end else begin
      mant = carry ? '0 : rsum[MANT_BITS-1:0];
      e    = e0;
    end
    efield   = EXP_FIELD_W'(e + exp_t'(EXP_BIAS)) & EXP_MASK;
    ovf_mant = sgn ? '0 : '1;
    word_nxt = '0;
    if (ef == DBL_EXP_SPECIAL) begin
      // infinity keeps its sign; NaN is positive overflow
      word_nxt[WORD_W-1] = (fr == '0) ? sgn : 1'b0;
      word_nxt[8 +: MANT_BITS] = word_nxt[WORD_W-1] ? '0 : '1;
      word_nxt[EXP_FIELD_W-1:0] = EXP_MASK;
    end else if (ef == DBL_EXP_DENORM || e < E_MIN) begin
      word_nxt = '0;
    end else if (e > E_TOP) begin
      word_nxt[WORD_W-1] = sgn;
      word_nxt[8 +: MANT_BITS] = ovf_mant;
      word_nxt[EXP_FIELD_W-1:0] = EXP_MASK;
    end else begin
      word_nxt[WORD_W-1] = sgn;
      word_nxt[8 +: MANT_BITS] = mant;
      word_nxt[EXP_FIELD_W-1:0] = efield;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && adv) |=> out_valid)
    else $error("transaction lost between stages");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dtdf_pkg::*;

  localparam int MANT_BITS = 23;
  localparam int EXP_BIAS  = 128;
  localparam int EXP_MAX   = 255;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 60;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [63:0]       in_double_bits;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_dsp_word;

  double_to_dsp_float_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_double_bits (in_double_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dsp_word   (out_dsp_word)
  );

  logic [63:0]       pending_doubles[$];
  logic [WORD_W-1:0] expected_words[$];
  int                error_count;
  int                idle_cycles;
  bit                drain_request;
  bit                long_hold;
  bit                in_taken;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [WORD_W-1:0] pack_dsp(logic [63:0] mant, int e, bit neg);
    logic [63:0] mmask;
    logic [31:0] biased;
    logic [WORD_W-1:0] w;
    mmask = (64'd1 << MANT_BITS) - 64'd1;
    biased = e + EXP_BIAS;
    w = 32'((mant & mmask) << 8) | 32'(biased & EXP_MAX);
    if (neg) w[31] = 1'b1;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] dsp_from_double(logic [63:0] b);
    bit          sgn;
    logic [10:0] ef;
    logic [63:0] sig;
    logic [63:0] v;
    int          e;
    sgn = b[63];
    ef  = b[62:52];
    if (ef == DBL_EXP_SPECIAL)
      return pack_dsp((b[51:0] == 0 && sgn) ? 64'd0 : '1, EXP_MAX - EXP_BIAS,
                      b[51:0] == 0 && sgn);
    if (ef == DBL_EXP_DENORM && b[51:0] == 0) return '0;
    if (ef == DBL_EXP_DENORM) begin
      sig = {12'd0, b[51:0]};
      e = -1022;
      while (sig[52] == 1'b0) begin
        sig = sig << 1;
        e--;
      end
    end else begin
      sig = {11'd0, 1'b1, b[51:0]};
      e = int'(ef) - DBL_BIAS;
    end
    v = sig >> (52 - MANT_BITS);
    if (sig[51 - MANT_BITS]) v++;
    if ((v >> (MANT_BITS + 1)) != 0) begin
      v = v >> 1;
      e++;
    end
    if (sgn) begin
      v = 64'd0 - v;
      if (v[MANT_BITS]) begin
        v = v << 1;
        e--;
      end
    end
    if (v == 0 || e < -(EXP_BIAS - 1)) return '0;
    if (e > EXP_MAX - EXP_BIAS) return pack_dsp(sgn ? 64'd0 : '1, EXP_MAX - EXP_BIAS, sgn);
    return pack_dsp(v, e, sgn);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] b;
    int pick;
    b = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    case (pick)
      0: b[62:52] = 11'(DBL_BIAS - 127 + $urandom_range(0, 3)) - 11'd2;
      1: b[62:52] = 11'(DBL_BIAS + 126 + $urandom_range(0, 3));
      2: b[28:0] = $urandom_range(0, 1) ? 29'h1FFF_FFFF : 29'h1000_0000;
      3: b[51:0] = '0;
      4: b[62:52] = $urandom_range(0, 1) ? DBL_EXP_SPECIAL : DBL_EXP_DENORM;
      default: b[62:52] = 11'(DBL_BIAS - 120 + $urandom_range(0, 240));
    endcase
    return b;
  endfunction

  // Remember whether the offered transaction went in at the last rising edge.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // Driver: bursts of valid with random gaps, hold payload while stalled.
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold
    end else if (drain_request || pending_doubles.size() == 0) begin
      in_valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else begin
      in_double_bits <= pending_doubles.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 20);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off.
  int stall_phase;
  int hold_count;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (long_hold && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else if (stall_phase[9]) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (stall_phase % 7 == 3) || ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_words.push_back(dsp_from_double(in_double_bits));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_dsp_word));
        end else begin
          logic [WORD_W-1:0] want;
          want = expected_words.pop_front();
          if (out_dsp_word !== want)
            report_mismatch($sformatf("dsp_word %h, expected %h", out_dsp_word, want));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] directed[$];
    in_valid = 1'b0;
    in_double_bits = '0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    hold_count = 0;
    long_hold = 1'b0;
    drain_request = 1'b0;
    directed = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                 64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
                 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
                 64'h3FFF_FFFF_F000_0000, 64'hBFFF_FFFF_F000_0000,
                 64'h3FFF_FFFF_E000_0000, 64'hBFF0_0000_1000_0000,
                 64'h3810_0000_0000_0000, 64'h380F_FFFF_FFFF_FFFF,
                 64'hB800_0000_0000_0000, 64'h47EF_FFFF_E000_0000,
                 64'h47EF_FFFF_F000_0000, 64'hC7F0_0000_0000_0000,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
    foreach (directed[i]) pending_doubles.push_back(directed[i]);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // Sender pauses until every expected result has arrived.
    wait (pending_doubles.size() == 0);
    drain_request = 1'b1;
    wait (expected_words.size() == 0 && !in_valid);
    drain_request = 1'b0;
    for (int i = 0; i < 1200; i++) pending_doubles.push_back(rand_double());
    // Block fills while the receiver holds off.
    long_hold = 1'b1;
    wait (pending_doubles.size() == 0);
    wait (!in_valid && expected_words.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
